// ===== src/swept_box_collision_resolve_core_macros.svh =====
// assertion macros shared by the collision resolve core
`ifndef SWEPT_BOX_COLLISION_RESOLVE_CORE_MACROS_SVH
`define SWEPT_BOX_COLLISION_RESOLVE_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define SBCR_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define SBCR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the trigger
`define SBCR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sbcr_pkg.sv =====
// shared widths, constants and codes of the swept box collision resolve core
package sbcr_pkg;

	// field widths
	localparam int COORD_W = 32;
	localparam int SIZE_W  = 31;
	localparam int FTIME_W = 24;
	localparam int FRAC_W  = 16;
	localparam int CT_W    = 16;
	localparam int CODE_W  = 3;

	// derived datapath widths
	localparam int PROD_W = COORD_W + FTIME_W;
	localparam int DISP_W = PROD_W - FRAC_W;
	localparam int DIFF_W = COORD_W + 2;
	localparam int NUM_W  = DIFF_W + FRAC_W;

	// slab times are resolved to QUO_W quotient bits, larger ones saturate
	localparam int QUO_W   = 18;
	localparam int HEAD_W  = NUM_W - QUO_W;
	localparam int TIME_W  = QUO_W + 2;
	localparam int DIV_LAT = QUO_W + 1;

	localparam logic signed [TIME_W-1:0] TIME_POS_SAT = TIME_W'(2 ** QUO_W);
	localparam logic signed [TIME_W-1:0] TIME_NEG_SAT = -TIME_POS_SAT - TIME_W'(1);
	localparam logic signed [TIME_W-1:0] TIME_ONE     = TIME_W'(2 ** FRAC_W);

	// face normal codes
	typedef enum logic [CODE_W-1:0] {
		NORM_NONE  = 3'd0,
		NORM_NEG_X = 3'd1,
		NORM_POS_X = 3'd2,
		NORM_NEG_Y = 3'd3,
		NORM_POS_Y = 3'd4
	} normal_code_t;

endpackage

// ===== src/sbcr_if.sv =====
// query and result channels of the collision resolve core

interface sbcr_query_if;
	import sbcr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] dyn_left;
	logic signed [COORD_W-1:0] dyn_top;
	logic        [SIZE_W-1:0]  dyn_width;
	logic        [SIZE_W-1:0]  dyn_height;
	logic signed [COORD_W-1:0] vel_x;
	logic signed [COORD_W-1:0] vel_y;
	logic        [FTIME_W-1:0] frame_time;
	logic signed [COORD_W-1:0] stat_left;
	logic signed [COORD_W-1:0] stat_top;
	logic        [SIZE_W-1:0]  stat_width;
	logic        [SIZE_W-1:0]  stat_height;

	modport source (
		output valid, dyn_left, dyn_top, dyn_width, dyn_height, vel_x, vel_y,
			frame_time, stat_left, stat_top, stat_width, stat_height,
		input  ready
	);
	modport sink (
		input  valid, dyn_left, dyn_top, dyn_width, dyn_height, vel_x, vel_y,
			frame_time, stat_left, stat_top, stat_width, stat_height,
		output ready
	);
endinterface

interface sbcr_result_if;
	import sbcr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic        [CT_W-1:0]    contact_time;
	logic signed [COORD_W-1:0] contact_x;
	logic signed [COORD_W-1:0] contact_y;
	logic        [CODE_W-1:0]  normal_code;
	logic signed [COORD_W-1:0] new_vel_x;
	logic signed [COORD_W-1:0] new_vel_y;

	modport source (
		output valid, hit, contact_time, contact_x, contact_y, normal_code,
			new_vel_x, new_vel_y,
		input  ready
	);
	modport sink (
		input  valid, hit, contact_time, contact_x, contact_y, normal_code,
			new_vel_x, new_vel_y,
		output ready
	);
endinterface

// ===== src/sbcr_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module sbcr_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [sbcr_pkg::NUM_W-1:0]   num,
	input  logic [sbcr_pkg::DISP_W-1:0]  den,
	output logic [sbcr_pkg::QUO_W-1:0]   quo,
	output logic                         rem_nz,
	output logic                         ovf
);
	import sbcr_pkg::*;

	// partial remainder, dividend bits shifting out with quotient bits shifting in
	logic [DISP_W-1:0] rem_q  [DIV_LAT];
	logic [QUO_W-1:0]  bits_q [DIV_LAT];
	logic [DISP_W-1:0] den_q  [DIV_LAT];
	logic              ovf_q  [DIV_LAT];

	// load: upper dividend part starts the remainder, quotient too wide flags overflow
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= {{(DISP_W-HEAD_W){1'b0}}, num[NUM_W-1:QUO_W]};
			bits_q[0] <= num[QUO_W-1:0];
			den_q[0]  <= den;
			ovf_q[0]  <= {{(DISP_W-HEAD_W){1'b0}}, num[NUM_W-1:QUO_W]} >= den;
		end
	end

	// one trial subtraction per stage
	for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
		logic [DISP_W:0] trial;
		logic [DISP_W:0] diff;

		assign trial = {rem_q[j-1], bits_q[j-1][QUO_W-1]};
		assign diff  = trial - {1'b0, den_q[j-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[DISP_W]) begin
					rem_q[j]  <= diff[DISP_W-1:0];
					bits_q[j] <= {bits_q[j-1][QUO_W-2:0], 1'b1};
				end else begin
					rem_q[j]  <= trial[DISP_W-1:0];
					bits_q[j] <= {bits_q[j-1][QUO_W-2:0], 1'b0};
				end
				den_q[j] <= den_q[j-1];
				ovf_q[j] <= ovf_q[j-1];
			end
		end
	end

	assign quo    = bits_q[DIV_LAT-1];
	assign rem_nz = |rem_q[DIV_LAT-1];
	assign ovf    = ovf_q[DIV_LAT-1];

endmodule

// ===== src/swept_box_collision_resolve_core.sv =====
// top level of the swept box collision resolve core
// throughput one query per cycle while the result queue has room
// the four slab bounds go through 19-stage restoring dividers: a load stage, then one quotient bit per stage
// a two-entry result queue decouples the pipeline from the result channel
// query ready drops only while the queue is full; the whole pipeline then holds
// reset clears stage valid bits and queue pointers; no warm-up after reset
`include "swept_box_collision_resolve_core_macros.svh"

module swept_box_collision_resolve_core (
	input  logic          clk,
	input  logic          arst_n,
	sbcr_query_if.sink    query,
	sbcr_result_if.source result
);
	import sbcr_pkg::*;

	localparam int NSTG       = DIV_LAT + 4;
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int TD_W       = CT_W + 1 + DISP_W;
	localparam int SUM_W      = TD_W + 1;
	localparam int SAT_W      = SUM_W - FRAC_W;
	localparam int RS_W       = CT_W + 1;
	localparam int CV_W       = COORD_W + RS_W;
	localparam int CORR_W     = CV_W - FRAC_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] vx;
		logic signed [COORD_W-1:0] vy;
		logic signed [DISP_W-1:0]  dx;
		logic signed [DISP_W-1:0]  dy;
		logic signed [DIFF_W-1:0]  cxs;
		logic signed [DIFF_W-1:0]  cys;
	} carry_t;

	typedef struct packed {
		carry_t c;
		logic   moving;
		logic   zx;
		logic   zy;
		logic   ins_x;
		logic   ins_y;
		logic   neg_nx;
		logic   neg_fx;
		logic   neg_ny;
		logic   neg_fy;
	} side_t;

	typedef struct packed {
		logic                      hit;
		logic        [CT_W-1:0]    contact_time;
		logic signed [COORD_W-1:0] contact_x;
		logic signed [COORD_W-1:0] contact_y;
		normal_code_t              normal_code;
		logic signed [COORD_W-1:0] new_vel_x;
		logic signed [COORD_W-1:0] new_vel_y;
	} result_t;

	function automatic logic signed [DIFF_W-1:0] sx_diff(input logic signed [COORD_W-1:0] v);
		return {{(DIFF_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

	function automatic logic signed [DIFF_W-1:0] zx_diff(input logic [SIZE_W-1:0] v);
		return {{(DIFF_W-SIZE_W){1'b0}}, v};
	endfunction

	// signed floor quotient from magnitude result, saturated outside the kept range
	function automatic logic signed [TIME_W-1:0] fin_time(input logic [QUO_W-1:0] q,
			input logic rnz, input logic ov, input logic neg);
		logic signed [TIME_W-1:0] qs;
		qs = {{(TIME_W-QUO_W){1'b0}}, q};
		if (ov)
			return neg ? TIME_NEG_SAT : TIME_POS_SAT;
		else if (neg)
			return -qs - {{(TIME_W-1){1'b0}}, rnz};
		else
			return qs;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[SAT_W-1:COORD_W-1];
		all_zero = ~|v[SAT_W-1:COORD_W-1];
		if (all_one || all_zero)
			return v[COORD_W-1:0];
		else if (v[SAT_W-1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	// pipeline control: every stage advances together while the queue has room
	logic              en;
	logic              push;
	logic              pop;
	logic [NSTG-1:0]   stg_vld_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	result_t           fifo_q [FIFO_DEPTH];

	assign en          = cnt_q != CNT_W'(FIFO_DEPTH);
	assign push        = en && stg_vld_q[NSTG-1];
	assign pop         = result.valid && result.ready;
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else if (en) begin
			stg_vld_q <= {stg_vld_q[NSTG-2:0], query.valid};
		end
	end

	// stage 1: displacement products and slab edge differences
	logic signed [PROD_W:0]    px_c, py_c;
	logic signed [PROD_W-1:0]  px_s1, py_s1;
	logic signed [DIFF_W-1:0]  dnx_s1, dfx_s1, dny_s1, dfy_s1;
	logic signed [DIFF_W-1:0]  cxs_s1, cys_s1;
	logic signed [COORD_W-1:0] vx_s1, vy_s1;
	logic signed [DIFF_W-1:0]  dl2_c, dt2_c;

	assign px_c  = query.vel_x * $signed({1'b0, query.frame_time});
	assign py_c  = query.vel_y * $signed({1'b0, query.frame_time});
	assign dl2_c = sx_diff(query.dyn_left);
	assign dt2_c = sx_diff(query.dyn_top);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= px_c[PROD_W-1:0];
			py_s1  <= py_c[PROD_W-1:0];
			dnx_s1 <= sx_diff(query.stat_left) - dl2_c - zx_diff(query.dyn_width);
			dfx_s1 <= sx_diff(query.stat_left) + zx_diff(query.stat_width) - dl2_c;
			dny_s1 <= sx_diff(query.stat_top) - dt2_c - zx_diff(query.dyn_height);
			dfy_s1 <= sx_diff(query.stat_top) + zx_diff(query.stat_height) - dt2_c;
			cxs_s1 <= {dl2_c[DIFF_W-2:0], 1'b0} + zx_diff(query.dyn_width);
			cys_s1 <= {dt2_c[DIFF_W-2:0], 1'b0} + zx_diff(query.dyn_height);
			vx_s1  <= query.vel_x;
			vy_s1  <= query.vel_y;
		end
	end

	// stage 2 entry: floored displacement, magnitudes and quotient signs
	logic signed [DISP_W-1:0] dx_c, dy_c;
	logic [DISP_W-1:0]        dxa_c, dya_c;
	logic [DIFF_W-1:0]        nxa_c, fxa_c, nya_c, fya_c;
	side_t                    side_c;
	side_t                    side_q [DIV_LAT];

	assign dx_c  = px_s1[PROD_W-1:FRAC_W];
	assign dy_c  = py_s1[PROD_W-1:FRAC_W];
	assign dxa_c = dx_c[DISP_W-1] ? (~dx_c) + 1'b1 : dx_c;
	assign dya_c = dy_c[DISP_W-1] ? (~dy_c) + 1'b1 : dy_c;
	assign nxa_c = dnx_s1[DIFF_W-1] ? (~dnx_s1) + 1'b1 : dnx_s1;
	assign fxa_c = dfx_s1[DIFF_W-1] ? (~dfx_s1) + 1'b1 : dfx_s1;
	assign nya_c = dny_s1[DIFF_W-1] ? (~dny_s1) + 1'b1 : dny_s1;
	assign fya_c = dfy_s1[DIFF_W-1] ? (~dfy_s1) + 1'b1 : dfy_s1;

	always_comb begin
		side_c.c.vx   = vx_s1;
		side_c.c.vy   = vy_s1;
		side_c.c.dx   = dx_c;
		side_c.c.dy   = dy_c;
		side_c.c.cxs  = cxs_s1;
		side_c.c.cys  = cys_s1;
		side_c.moving = (vx_s1 != '0) || (vy_s1 != '0);
		side_c.zx     = dx_c == '0;
		side_c.zy     = dy_c == '0;
		side_c.ins_x  = dnx_s1[DIFF_W-1] && !dfx_s1[DIFF_W-1] && (dfx_s1 != '0);
		side_c.ins_y  = dny_s1[DIFF_W-1] && !dfy_s1[DIFF_W-1] && (dfy_s1 != '0);
		side_c.neg_nx = dnx_s1[DIFF_W-1] ^ dx_c[DISP_W-1];
		side_c.neg_fx = dfx_s1[DIFF_W-1] ^ dx_c[DISP_W-1];
		side_c.neg_ny = dny_s1[DIFF_W-1] ^ dy_c[DISP_W-1];
		side_c.neg_fy = dfy_s1[DIFF_W-1] ^ dy_c[DISP_W-1];
	end

	// side data rides alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_c;
			for (int j = 1; j < DIV_LAT; j++)
				side_q[j] <= side_q[j-1];
		end
	end

	// stages 2 to 20: slab bound dividers
	logic [QUO_W-1:0] q_nx, q_fx, q_ny, q_fy;
	logic             rz_nx, rz_fx, rz_ny, rz_fy;
	logic             ov_nx, ov_fx, ov_ny, ov_fy;

	sbcr_div u_div_nx (.clk(clk), .en(en), .num({nxa_c, {FRAC_W{1'b0}}}), .den(dxa_c),
		.quo(q_nx), .rem_nz(rz_nx), .ovf(ov_nx));
	sbcr_div u_div_fx (.clk(clk), .en(en), .num({fxa_c, {FRAC_W{1'b0}}}), .den(dxa_c),
		.quo(q_fx), .rem_nz(rz_fx), .ovf(ov_fx));
	sbcr_div u_div_ny (.clk(clk), .en(en), .num({nya_c, {FRAC_W{1'b0}}}), .den(dya_c),
		.quo(q_ny), .rem_nz(rz_ny), .ovf(ov_ny));
	sbcr_div u_div_fy (.clk(clk), .en(en), .num({fya_c, {FRAC_W{1'b0}}}), .den(dya_c),
		.quo(q_fy), .rem_nz(rz_fy), .ovf(ov_fy));

	// stage 21: signed slab intervals, zero displacement spans all time
	side_t                    sd;
	logic signed [TIME_W-1:0] anx_c, afx_c, any_c, afy_c;
	logic signed [TIME_W-1:0] lox_s21, hix_s21, loy_s21, hiy_s21;
	logic                     okx_s21, oky_s21, moving_s21;
	carry_t                   c_s21;

	assign sd    = side_q[DIV_LAT-1];
	assign anx_c = fin_time(q_nx, rz_nx, ov_nx, sd.neg_nx);
	assign afx_c = fin_time(q_fx, rz_fx, ov_fx, sd.neg_fx);
	assign any_c = fin_time(q_ny, rz_ny, ov_ny, sd.neg_ny);
	assign afy_c = fin_time(q_fy, rz_fy, ov_fy, sd.neg_fy);

	always_ff @(posedge clk) begin
		if (en) begin
			lox_s21    <= sd.zx ? TIME_NEG_SAT : ((anx_c < afx_c) ? anx_c : afx_c);
			hix_s21    <= sd.zx ? TIME_POS_SAT : ((anx_c < afx_c) ? afx_c : anx_c);
			loy_s21    <= sd.zy ? TIME_NEG_SAT : ((any_c < afy_c) ? any_c : afy_c);
			hiy_s21    <= sd.zy ? TIME_POS_SAT : ((any_c < afy_c) ? afy_c : any_c);
			okx_s21    <= sd.zx ? sd.ins_x : 1'b1;
			oky_s21    <= sd.zy ? sd.ins_y : 1'b1;
			moving_s21 <= sd.moving;
			c_s21      <= sd.c;
		end
	end

	// stage 22: entry time, hit decision and face normal
	logic signed [TIME_W-1:0] tnear_c, tfar_c;
	logic                     hit_c;
	normal_code_t             code_c;
	logic                     hit_s22;
	logic [CT_W-1:0]          t_s22;
	normal_code_t             code_s22;
	carry_t                   c_s22;

	assign tnear_c = (lox_s21 > loy_s21) ? lox_s21 : loy_s21;
	assign tfar_c  = (hix_s21 < hiy_s21) ? hix_s21 : hiy_s21;
	assign hit_c   = moving_s21 && okx_s21 && oky_s21
		&& !(lox_s21 > hiy_s21 || loy_s21 > hix_s21)
		&& !tfar_c[TIME_W-1] && !tnear_c[TIME_W-1] && (tnear_c < TIME_ONE);

	always_comb begin
		code_c = NORM_NONE;
		if (hit_c) begin
			if (lox_s21 > loy_s21)
				code_c = c_s21.dx[DISP_W-1] ? NORM_POS_X : NORM_NEG_X;
			else if (lox_s21 < loy_s21)
				code_c = c_s21.dy[DISP_W-1] ? NORM_POS_Y : NORM_NEG_Y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s22  <= hit_c;
			t_s22    <= hit_c ? tnear_c[CT_W-1:0] : '0;
			code_s22 <= code_c;
			c_s22    <= c_s21;
		end
	end

	// stage 23: contact offsets and velocity correction products
	logic signed [TD_W-1:0]   tdx_c, tdy_c;
	logic [COORD_W-1:0]       ax_c, ay_c;
	logic [RS_W-1:0]          rest_c;
	logic signed [TD_W-1:0]   tdx_s23, tdy_s23;
	logic [CV_W-1:0]          cvx_s23, cvy_s23;
	logic                     hit_s23;
	logic [CT_W-1:0]          t_s23;
	normal_code_t             code_s23;
	carry_t                   c_s23;

	assign tdx_c  = $signed({1'b0, t_s22}) * c_s22.dx;
	assign tdy_c  = $signed({1'b0, t_s22}) * c_s22.dy;
	assign ax_c   = c_s22.vx[COORD_W-1] ? (~c_s22.vx) + 1'b1 : c_s22.vx;
	assign ay_c   = c_s22.vy[COORD_W-1] ? (~c_s22.vy) + 1'b1 : c_s22.vy;
	assign rest_c = RS_W'(2 ** FRAC_W) - {1'b0, t_s22};

	always_ff @(posedge clk) begin
		if (en) begin
			tdx_s23  <= tdx_c;
			tdy_s23  <= tdy_c;
			cvx_s23  <= ax_c * rest_c;
			cvy_s23  <= ay_c * rest_c;
			hit_s23  <= hit_s22;
			t_s23    <= t_s22;
			code_s23 <= code_s22;
			c_s23    <= c_s22;
		end
	end

	// final sums, floors and saturation into the result queue
	logic signed [SUM_W-1:0]   csx_c, csy_c;
	logic signed [SAT_W-1:0]   vxe_c, vye_c, cxe_c, cye_c;
	logic signed [SAT_W-1:0]   nvx_c, nvy_c;
	result_t                   res_c;

	assign csx_c = {{(SUM_W-DIFF_W-FRAC_W+1){c_s23.cxs[DIFF_W-1]}}, c_s23.cxs,
		{(FRAC_W-1){1'b0}}} + {tdx_s23[TD_W-1], tdx_s23};
	assign csy_c = {{(SUM_W-DIFF_W-FRAC_W+1){c_s23.cys[DIFF_W-1]}}, c_s23.cys,
		{(FRAC_W-1){1'b0}}} + {tdy_s23[TD_W-1], tdy_s23};
	assign vxe_c = {{(SAT_W-COORD_W){c_s23.vx[COORD_W-1]}}, c_s23.vx};
	assign vye_c = {{(SAT_W-COORD_W){c_s23.vy[COORD_W-1]}}, c_s23.vy};
	assign cxe_c = {{(SAT_W-CORR_W){1'b0}}, cvx_s23[CV_W-1:FRAC_W]};
	assign cye_c = {{(SAT_W-CORR_W){1'b0}}, cvy_s23[CV_W-1:FRAC_W]};

	always_comb begin
		case (code_s23)
			NORM_POS_X: nvx_c = vxe_c + cxe_c;
			NORM_NEG_X: nvx_c = vxe_c - cxe_c;
			default:    nvx_c = vxe_c;
		endcase
		case (code_s23)
			NORM_POS_Y: nvy_c = vye_c + cye_c;
			NORM_NEG_Y: nvy_c = vye_c - cye_c;
			default:    nvy_c = vye_c;
		endcase
	end

	always_comb begin
		res_c.hit          = hit_s23;
		res_c.contact_time = t_s23;
		res_c.contact_x    = hit_s23 ? sat_coord(csx_c[SUM_W-1:FRAC_W]) : '0;
		res_c.contact_y    = hit_s23 ? sat_coord(csy_c[SUM_W-1:FRAC_W]) : '0;
		res_c.normal_code  = code_s23;
		res_c.new_vel_x    = sat_coord(nvx_c);
		res_c.new_vel_y    = sat_coord(nvy_c);
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= res_c;
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// result beat
	assign result.valid        = cnt_q != '0;
	assign result.hit          = fifo_q[rd_ptr_q].hit;
	assign result.contact_time = fifo_q[rd_ptr_q].contact_time;
	assign result.contact_x    = fifo_q[rd_ptr_q].contact_x;
	assign result.contact_y    = fifo_q[rd_ptr_q].contact_y;
	assign result.normal_code  = fifo_q[rd_ptr_q].normal_code;
	assign result.new_vel_x    = fifo_q[rd_ptr_q].new_vel_x;
	assign result.new_vel_y    = fifo_q[rd_ptr_q].new_vel_y;

	// checks
	`SBCR_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(FIFO_DEPTH), "result queue over capacity")
	`SBCR_ASSERT_IMP(a_miss_clean, result.valid && !result.hit, result.contact_time == '0 && result.normal_code == NORM_NONE && result.contact_x == '0 && result.contact_y == '0, "miss beat carries contact data")
	`SBCR_ASSERT_NEXT(a_fill_stall, cnt_q == CNT_W'(1) && push && !pop, !query.ready, "query taken with full result queue")
	`SBCR_ASSERT_NEXT(a_push_shows, push, result.valid, "pushed result not offered")

endmodule

// ===== tb/sbcr_checker.sv =====
// beat monitor, collision predictor and result scoreboard for the collision resolve core
`timescale 1ns / 100ps

module sbcr_checker
	import sbcr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sbcr_query_if         query,
	sbcr_result_if        result,
	output int            mismatches,
	output int            pending,
	output int            checked,
	output int            hits_seen
);

	localparam longint SLAB_INF = longint'(1) <<< 60;
	localparam longint UNIT     = 65536;

	typedef struct {
		logic                      hit;
		logic        [CT_W-1:0]    contact_time;
		logic signed [COORD_W-1:0] contact_x;
		logic signed [COORD_W-1:0] contact_y;
		normal_code_t              normal_code;
		logic signed [COORD_W-1:0] new_vel_x;
		logic signed [COORD_W-1:0] new_vel_y;
	} contact_t;

	contact_t contact_q[$];

	// division rounded toward minus infinity
	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q--;
		return q;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// entry and exit times of the ray through one slab
	function automatic bit slab_span(input longint near_gap, input longint far_gap,
			input longint disp, output longint lo, output longint hi);
		longint a;
		longint b;
		lo = 0;
		hi = 0;
		if (disp == 0) begin
			if (near_gap < 0 && far_gap > 0) begin
				lo = -SLAB_INF;
				hi = SLAB_INF;
				return 1'b1;
			end
			return 1'b0;
		end
		a = floor_div(near_gap * UNIT, disp);
		b = floor_div(far_gap * UNIT, disp);
		lo = (a > b) ? b : a;
		hi = (a > b) ? a : b;
		return 1'b1;
	endfunction

	// expected contact for the query on the channel right now
	function automatic contact_t resolve_contact();
		contact_t r;
		longint dl, dtop, dw, dh, vx, vy, ft, sl, st, sw, sh;
		longint dx, dy, xlo, xhi, ylo, yhi, tnear, tfar, t, rem, nx, ny;
		dl   = longint'(query.dyn_left);
		dtop = longint'(query.dyn_top);
		dw   = longint'({1'b0, query.dyn_width});
		dh   = longint'({1'b0, query.dyn_height});
		vx   = longint'(query.vel_x);
		vy   = longint'(query.vel_y);
		ft   = longint'({1'b0, query.frame_time});
		sl   = longint'(query.stat_left);
		st   = longint'(query.stat_top);
		sw   = longint'({1'b0, query.stat_width});
		sh   = longint'({1'b0, query.stat_height});
		r.hit          = 1'b0;
		r.contact_time = '0;
		r.contact_x    = '0;
		r.contact_y    = '0;
		r.normal_code  = NORM_NONE;
		r.new_vel_x    = query.vel_x;
		r.new_vel_y    = query.vel_y;
		if (vx == 0 && vy == 0)
			return r;
		dx = floor_div(vx * ft, UNIT);
		dy = floor_div(vy * ft, UNIT);
		if (!slab_span(sl - dl - dw, sl + sw - dl, dx, xlo, xhi))
			return r;
		if (!slab_span(st - dtop - dh, st + sh - dtop, dy, ylo, yhi))
			return r;
		if (xlo > yhi || ylo > xhi)
			return r;
		tnear = (xlo > ylo) ? xlo : ylo;
		tfar  = (xhi < yhi) ? xhi : yhi;
		if (tfar < 0 || tnear < 0 || tnear >= UNIT)
			return r;
		t = tnear;
		r.hit          = 1'b1;
		r.contact_time = t[CT_W-1:0];
		r.contact_x    = COORD_W'(clamp32(floor_div((2 * dl + dw) * 32768 + t * dx, UNIT)));
		r.contact_y    = COORD_W'(clamp32(floor_div((2 * dtop + dh) * 32768 + t * dy, UNIT)));
		nx = 0;
		ny = 0;
		// face hit last decides the normal; equal times mean a corner
		if (xlo > ylo) begin
			nx = (dx < 0) ? 1 : -1;
			r.normal_code = (dx < 0) ? NORM_POS_X : NORM_NEG_X;
		end else if (xlo < ylo) begin
			ny = (dy < 0) ? 1 : -1;
			r.normal_code = (dy < 0) ? NORM_POS_Y : NORM_NEG_Y;
		end
		rem = UNIT - t;
		r.new_vel_x = COORD_W'(clamp32(vx + nx * (((vx < 0) ? -vx : vx) * rem / UNIT)));
		r.new_vel_y = COORD_W'(clamp32(vy + ny * (((vy < 0) ? -vy : vy) * rem / UNIT)));
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
		checked    = 0;
		hits_seen  = 0;
	end

	assign pending = contact_q.size();

	// compare the result beat, then queue the prediction for the query beat
	always @(posedge clk) begin
		contact_t want;
		if (arst_n && result.valid && result.ready) begin
			if (contact_q.size() == 0) begin
				$display("%0t mismatch result beat with nothing expected, hit %b",
					$time, result.hit);
				mismatches++;
			end else begin
				want = contact_q.pop_front();
				checked++;
				if (want.hit)
					hits_seen++;
				compare_field("hit", want.hit, result.hit);
				compare_field("contact_time", want.contact_time, result.contact_time);
				compare_field("contact_x", want.contact_x, result.contact_x);
				compare_field("contact_y", want.contact_y, result.contact_y);
				compare_field("normal_code", want.normal_code, result.normal_code);
				compare_field("new_vel_x", want.new_vel_x, result.new_vel_x);
				compare_field("new_vel_y", want.new_vel_y, result.new_vel_y);
			end
		end
		if (arst_n && query.valid && query.ready)
			contact_q.insert(contact_q.size(), resolve_contact());
	end

endmodule

// ===== tb/testbench.sv =====
// stimulus, clocking, reset and verdict for the collision resolve core
`timescale 1ns / 100ps

module testbench;
	import sbcr_pkg::*;

	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_ITEMS   = 120;
	localparam int STALL_LIMIT  = 4000;

	typedef struct {
		longint dyn_left, dyn_top, dyn_width, dyn_height, vel_x, vel_y;
		longint frame_time, stat_left, stat_top, stat_width, stat_height;
	} box_query_t;

	logic clk;
	logic arst_n;
	bit   calm;
	int   mismatches, pending, checked, hits_seen;
	int   idle_cycles;
	int   sent;

	sbcr_query_if  query ();
	sbcr_result_if result ();

	swept_box_collision_resolve_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query.sink),
		.result (result.source)
	);

	sbcr_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.query      (query),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.hits_seen  (hits_seen)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		query.valid      = 1'b0;
		query.dyn_left   = '0;
		query.dyn_top    = '0;
		query.dyn_width  = '0;
		query.dyn_height = '0;
		query.vel_x      = '0;
		query.vel_y      = '0;
		query.frame_time = '0;
		query.stat_left  = '0;
		query.stat_top   = '0;
		query.stat_width = '0;
		query.stat_height = '0;
		result.ready     = 1'b0;
	end

	// result side stalls in random bursts until the calm tail
	always @(posedge clk) begin
		int burst;
		if (arst_n) begin
			if (!calm && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 18);
				result.ready <= 1'b0;
				repeat (burst - 1) @(posedge clk);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (query.valid && query.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", pending);
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic longint spread(input longint r);
		return longint'($urandom_range(0, 32'(2 * r))) - r;
	endfunction

	// drive one query beat, with an optional gap before it
	task automatic send_query(input box_query_t b);
		bit taken;
		if (!calm && $urandom_range(0, 7) == 0) begin
			query.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		query.valid       <= 1'b1;
		query.dyn_left    <= b.dyn_left[31:0];
		query.dyn_top     <= b.dyn_top[31:0];
		query.dyn_width   <= b.dyn_width[30:0];
		query.dyn_height  <= b.dyn_height[30:0];
		query.vel_x       <= b.vel_x[31:0];
		query.vel_y       <= b.vel_y[31:0];
		query.frame_time  <= b.frame_time[23:0];
		query.stat_left   <= b.stat_left[31:0];
		query.stat_top    <= b.stat_top[31:0];
		query.stat_width  <= b.stat_width[30:0];
		query.stat_height <= b.stat_height[30:0];
		do begin
			@(negedge clk);
			taken = query.ready;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	function automatic box_query_t make_box(input longint dl, dt, dw, dh, vx, vy, ft,
			sl, st, sw, sh);
		box_query_t b;
		b.dyn_left = dl; b.dyn_top = dt; b.dyn_width = dw; b.dyn_height = dh;
		b.vel_x = vx; b.vel_y = vy; b.frame_time = ft;
		b.stat_left = sl; b.stat_top = st; b.stat_width = sw; b.stat_height = sh;
		return b;
	endfunction

	// random query, mostly aimed at the fixed box so that contacts are common
	function automatic box_query_t random_query();
		box_query_t b;
		longint gx, gy;
		if ($urandom_range(0, 4) == 0) begin
			b = make_box($urandom, $urandom, $urandom & 32'h7fffffff, $urandom & 32'h7fffffff,
				$urandom, $urandom, $urandom & 32'hffffff, $urandom, $urandom,
				$urandom & 32'h7fffffff, $urandom & 32'h7fffffff);
			return b;
		end
		b.stat_left   = spread(1 << 24);
		b.stat_top    = spread(1 << 24);
		b.stat_width  = $urandom_range(1, 1 << 22);
		b.stat_height = $urandom_range(1, 1 << 22);
		b.dyn_width   = $urandom_range(0, 1 << 21);
		b.dyn_height  = $urandom_range(0, 1 << 21);
		b.dyn_left    = b.stat_left + spread(1 << 23);
		b.dyn_top     = b.stat_top + spread(1 << 23);
		gx = (2 * b.stat_left + b.stat_width - 2 * b.dyn_left - b.dyn_width) / 2;
		gy = (2 * b.stat_top + b.stat_height - 2 * b.dyn_top - b.dyn_height) / 2;
		// sometimes line up on one axis so the ray runs straight along it
		case ($urandom_range(0, 5))
			0: begin b.dyn_top = b.stat_top + b.stat_height / 2 - b.dyn_height / 2; gy = 0; end
			1: begin b.dyn_left = b.stat_left + b.stat_width / 2 - b.dyn_width / 2; gx = 0; end
			default: ;
		endcase
		if ($urandom_range(0, 1)) begin
			b.frame_time = 65536;
			b.vel_x = gx + spread(1 << 21);
			b.vel_y = gy + spread(1 << 21);
		end else begin
			b.frame_time = $urandom_range(16384, 1 << 20);
			b.vel_x = (gx + spread(1 << 20)) * 65536 / b.frame_time;
			b.vel_y = (gy + spread(1 << 20)) * 65536 / b.frame_time;
		end
		if (gx == 0 && $urandom_range(0, 1)) b.vel_x = 0;
		if (gy == 0 && $urandom_range(0, 1)) b.vel_y = 0;
		return b;
	endfunction

	initial begin
		longint one;
		longint maxc;
		longint minc;
		longint maxs;
		one  = 65536;
		maxc = 64'sd2147483647;
		minc = -64'sd2147483648;
		maxs = 64'sd2147483647;
		calm = 1'b0;
		sent = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: face hits from each side, corner, misses, extremes
		send_query(make_box(0, 0, one, one, 0, 0, one, 4*one, 0, one, one));
		send_query(make_box(0, 0, one, one, 8*one, 0, one, 4*one, 0, one, one));
		send_query(make_box(8*one, 0, one, one, -8*one, 0, one, 4*one, 0, one, one));
		send_query(make_box(0, 0, one, one, 0, 8*one, one, 0, 4*one, one, one));
		send_query(make_box(0, 8*one, one, one, 0, -8*one, one, 0, 4*one, one, one));
		send_query(make_box(0, 0, one, one, 8*one, 8*one, one, 4*one, 4*one, one, one));
		send_query(make_box(0, 0, one, one, 8*one, 0, one, 4*one, 5*one, one, one));
		send_query(make_box(0, 0, one, one, 0, 8*one, one, 0, 4*one, one, one));
		send_query(make_box(0, 0, one, one, 8*one, 0, one, 4*one, one, one, one));
		send_query(make_box(0, 0, one, one, -8*one, 0, one, 4*one, 0, one, one));
		send_query(make_box(0, 0, one, one, 2*one, 0, one, 4*one, 0, one, one));
		send_query(make_box(4*one, 0, one, one, 8*one, 0, one, 4*one, 0, one, one));
		send_query(make_box(0, 0, one, one, 8*one, 3*one, 0, 4*one, 0, one, one));
		send_query(make_box(0, 0, one, one, 1, 0, 24'hffffff, 4*one, 0, one, one));
		send_query(make_box(minc, minc, maxs, maxs, maxc, maxc, 24'hffffff,
			maxc, maxc, maxs, maxs));
		send_query(make_box(maxc, maxc, 0, 0, minc, minc, 24'hffffff,
			minc, minc, maxs, maxs));
		send_query(make_box(minc, 0, 0, 0, maxc, 0, 24'hffffff, 0, minc, 0, maxs));
		send_query(make_box(maxc, minc, maxs, 0, minc, 1, one, minc, maxc, maxs, 0));
		send_query(make_box(-one, -one, one, one, -maxc, -1, 24'hffffff,
			-maxc, -maxc, one, maxs));

		// let the pipe drain completely before the random part
		query.valid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send_query(random_query());
		end
		query.valid <= 1'b0;

		wait (pending == 0);
		repeat (40) @(posedge clk);
		$display("sent %0d queries, checked %0d results, %0d of them contacts",
			sent, checked, hits_seen);
		$display("covered face, corner and miss cases, zero motion and field extremes");
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
